// ===== rtl/core/tfifo_pkg.sv =====
package tfifo_pkg;

	// field widths fixed by the item format
	localparam int ACTION_W = 2;
	localparam int TAG_W    = 3;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 5;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// largest capacity the 5-bit register can name
	localparam int CAP_LIMIT = 31;

	// actions
	localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

	// full-queue policies
	localparam logic [MODE_W-1:0] MODE_BLOCK     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DROP_NEW  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DROP_OLD  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL_REJECT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NEW_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OLD_DROPPED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TAG_MISMATCH = 3'd5;

	// tag value that matches any entry on a pop
	localparam logic [TAG_W-1:0] TAG_ANY = 3'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd1;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// per-slot control from the pointer logic
	typedef struct packed {
		logic wr_en;
		logic rd_sel;
	} cell_ctl_t;

endpackage

// ===== rtl/core/tfifo_if.sv =====
// command channel
interface tfifo_cmd_if #(
	parameter int PAYLOAD_BITS = 64
);
	logic                             valid;
	logic                             ready;
	logic [tfifo_pkg::ACTION_W-1:0]   action;
	logic [tfifo_pkg::TAG_W-1:0]      type_tag;
	logic [PAYLOAD_BITS-1:0]          payload_in;

	modport source (output valid, action, type_tag, payload_in, input ready);
	modport sink   (input valid, action, type_tag, payload_in, output ready);
endinterface

// result channel
interface tfifo_rsp_if #(
	parameter int PAYLOAD_BITS = 64
);
	logic                             valid;
	logic                             ready;
	logic [tfifo_pkg::STATUS_W-1:0]   status;
	logic [PAYLOAD_BITS-1:0]          payload_out;
	logic [tfifo_pkg::TAG_W-1:0]      type_out;
	logic                             is_empty;
	logic                             has_room;
	logic [tfifo_pkg::CNT_W-1:0]      entry_count;

	modport source (output valid, status, payload_out, type_out, is_empty, has_room,
		entry_count, input ready);
	modport sink   (input valid, status, payload_out, type_out, is_empty, has_room,
		entry_count, output ready);
endinterface

// register write channel
interface tfifo_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tfifo_pkg::CFG_IDX_W-1:0]   index;
	logic [tfifo_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tfifo_cell.sv =====
module tfifo_cell #(
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                          clk,
	input  tfifo_pkg::cell_ctl_t          ctl,
	input  logic [tfifo_pkg::TAG_W-1:0]   wr_tag,
	input  logic [PAYLOAD_BITS-1:0]       wr_payload,
	input  logic [tfifo_pkg::TAG_W-1:0]   rd_tag_prev,
	input  logic [PAYLOAD_BITS-1:0]       rd_payload_prev,
	output logic [tfifo_pkg::TAG_W-1:0]   rd_tag_next,
	output logic [PAYLOAD_BITS-1:0]       rd_payload_next
);

	logic [tfifo_pkg::TAG_W-1:0] tag_q;
	logic [PAYLOAD_BITS-1:0]     payload_q;

	// slot storage, written when the tail points here
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			tag_q     <= wr_tag;
			payload_q <= wr_payload;
		end
	end

	// read chain: merge own entry when the head points here
	assign rd_tag_next     = rd_tag_prev | (ctl.rd_sel ? tag_q : '0);
	assign rd_payload_next = rd_payload_prev | (ctl.rd_sel ? payload_q : '0);

endmodule

// ===== rtl/core/typed_fifo_with_overflow_modes.sv =====
// Typed ring-buffer queue with a configurable full-queue policy.
// The result is registered and valid in the cycle after the command transfer; the head slot is
// read through the cell chain. Throughput: one command per cycle while results are taken.
// The result register frees as its transfer completes, so a new command is taken alongside it.
// Reset clears pointers, count, policy (block) and capacity (16); slot contents are not reset.
module typed_fifo_with_overflow_modes #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tfifo_cmd_if.sink   cmd,
	tfifo_rsp_if.source rsp,
	tfifo_cfg_if.sink   cfg
);

	localparam int NCELL = (DEPTH < tfifo_pkg::CAP_LIMIT) ? DEPTH : tfifo_pkg::CAP_LIMIT;
	localparam int PTR_W = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int CW    = tfifo_pkg::CNT_W;
	localparam int TW    = tfifo_pkg::TAG_W;

	// configuration and pointer state
	logic [tfifo_pkg::MODE_W-1:0] full_mode_q;
	logic [CW-1:0]                capacity_q;
	logic [PTR_W-1:0]             head_q;
	logic [PTR_W-1:0]             tail_q;
	logic [CW-1:0]                count_q;

	// result register
	logic                         rsp_valid_q;
	logic [tfifo_pkg::STATUS_W-1:0] status_q;
	logic [PAYLOAD_BITS-1:0]      payload_q;
	logic [TW-1:0]                type_q;
	logic                         empty_q;
	logic                         room_q;
	logic [CW-1:0]                entry_count_q;

	logic                         cmd_fire;
	logic [CW-1:0]                cap_eff;
	logic                         is_full;
	logic                         do_store;
	logic                         do_drop;
	logic                         do_clear;
	logic [tfifo_pkg::STATUS_W-1:0] status_d;
	logic                         read_ok;
	logic [PTR_W-1:0]             head_d;
	logic [PTR_W-1:0]             tail_d;
	logic [CW-1:0]                count_d;

	logic [TW-1:0]                chain_tag [NCELL+1];
	logic [PAYLOAD_BITS-1:0]      chain_pay [NCELL+1];
	tfifo_pkg::cell_ctl_t         cell_ctl  [NCELL];

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
		input logic [CW-1:0] cap);
		logic [CW-1:0] nxt;
		nxt = CW'(ptr) + CW'(1);
		return (nxt >= cap) ? '0 : PTR_W'(nxt);
	endfunction

	assign cfg.ready = 1'b1;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// effective capacity: zero acts as one, above the slot count clamps
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (capacity_q > CW'(NCELL)) begin
			cap_eff = CW'(NCELL);
		end else begin
			cap_eff = capacity_q;
		end
	end

	assign is_full = (count_q >= cap_eff);

	// row of slot cells with the head read chain
	assign chain_tag[0] = '0;
	assign chain_pay[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		assign cell_ctl[i].wr_en  = cmd_fire && do_store && (tail_q == PTR_W'(i));
		assign cell_ctl[i].rd_sel = (head_q == PTR_W'(i));

		tfifo_cell #(
			.PAYLOAD_BITS(PAYLOAD_BITS)
		) u_cell (
			.clk             (clk),
			.ctl             (cell_ctl[i]),
			.wr_tag          (cmd.type_tag),
			.wr_payload      (cmd.payload_in),
			.rd_tag_prev     (chain_tag[i]),
			.rd_payload_prev (chain_pay[i]),
			.rd_tag_next     (chain_tag[i+1]),
			.rd_payload_next (chain_pay[i+1])
		);
	end

	// command decode and next pointer state
	always_comb begin
		do_store = 1'b0;
		do_drop  = 1'b0;
		do_clear = 1'b0;
		read_ok  = 1'b0;
		status_d = tfifo_pkg::ST_OK;
		unique case (cmd.action) inside
			tfifo_pkg::ACT_PUSH: begin
				if (!is_full) begin
					do_store = 1'b1;
				end else if (full_mode_q == tfifo_pkg::MODE_DROP_NEW) begin
					status_d = tfifo_pkg::ST_NEW_DROPPED;
				end else if (full_mode_q == tfifo_pkg::MODE_DROP_OLD) begin
					do_store = 1'b1;
					do_drop  = 1'b1;
					status_d = tfifo_pkg::ST_OLD_DROPPED;
				end else begin
					status_d = tfifo_pkg::ST_FULL_REJECT;
				end
			end
			tfifo_pkg::ACT_POP,
			tfifo_pkg::ACT_PEEK: begin
				if (count_q == '0) begin
					status_d = tfifo_pkg::ST_EMPTY;
				end else if (cmd.action == tfifo_pkg::ACT_POP
						&& cmd.type_tag != tfifo_pkg::TAG_ANY
						&& chain_tag[NCELL] != cmd.type_tag) begin
					status_d = tfifo_pkg::ST_TAG_MISMATCH;
				end else begin
					read_ok = 1'b1;
					do_drop = (cmd.action == tfifo_pkg::ACT_POP);
				end
			end
			tfifo_pkg::ACT_CLEAR: begin
				do_clear = 1'b1;
			end
			default: begin
				do_clear = 1'b0;
			end
		endcase

		head_d  = do_drop ? advance(head_q, cap_eff) : head_q;
		tail_d  = do_store ? advance(tail_q, cap_eff) : tail_q;
		count_d = count_q;
		if (do_store && !do_drop) begin
			count_d = count_q + CW'(1);
		end else if (do_drop && !do_store) begin
			count_d = count_q - CW'(1);
		end
		if (do_clear) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_mode_q <= tfifo_pkg::MODE_BLOCK;
			capacity_q  <= tfifo_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tfifo_pkg::REG_FULL_MODE: full_mode_q <= cfg.data[tfifo_pkg::MODE_W-1:0];
				tfifo_pkg::REG_CAPACITY:  capacity_q  <= cfg.data;
				default:                  capacity_q  <= capacity_q;
			endcase
		end
	end

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd_fire) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			status_q      <= status_d;
			payload_q     <= read_ok ? chain_pay[NCELL] : '0;
			type_q        <= read_ok ? chain_tag[NCELL] : '0;
			empty_q       <= (count_d == '0);
			room_q        <= (count_d < cap_eff);
			entry_count_q <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.payload_out = payload_q;
	assign rsp.type_out    = type_q;
	assign rsp.is_empty    = empty_q;
	assign rsp.has_room    = room_q;
	assign rsp.entry_count = entry_count_q;

endmodule

// ===== bench/typed_fifo_with_overflow_modes_tb.sv =====
`timescale 1ns / 1ps

module typed_fifo_with_overflow_modes_tb;

	localparam int PAY_W          = 64;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int PHASES         = 8;
	localparam int LONG_HOLD      = 80;
	localparam int REPORT_LIMIT   = 10;

	// field widths of the item format
	localparam int ACTION_W   = tfifo_pkg::ACTION_W;
	localparam int TAG_W      = tfifo_pkg::TAG_W;
	localparam int STATUS_W   = tfifo_pkg::STATUS_W;
	localparam int CNT_W      = tfifo_pkg::CNT_W;
	localparam int MODE_W     = tfifo_pkg::MODE_W;
	localparam int CFG_IDX_W  = tfifo_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = tfifo_pkg::CFG_DATA_W;

	// mode value outside the named policies, behaves as block
	localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [TAG_W-1:0]    tag;
		logic [PAY_W-1:0]    payload;
	} fifo_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAY_W-1:0]    payload;
		logic [TAG_W-1:0]    tag;
		logic                empty;
		logic                room;
		logic [CNT_W-1:0]    count;
	} fifo_res_t;

	typedef struct {
		fifo_cmd_t cmd;
		bit        fixed;
		fifo_res_t res;
	} opening_row_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0]  cap;
		int                push_pct;
		bit                calm;
		bit                hold;
	} phase_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tfifo_cmd_if #(.PAYLOAD_BITS(PAY_W)) cmd_ch ();
	tfifo_rsp_if #(.PAYLOAD_BITS(PAY_W)) rsp_ch ();
	tfifo_cfg_if                         cfg_ch ();

	typed_fifo_with_overflow_modes i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the queue contents and settings
	logic [PAY_W-1:0] shadow_pay [16];
	logic [TAG_W-1:0] shadow_tag [16];
	logic [3:0]        shadow_head = '0;
	logic [3:0]        shadow_tail = '0;
	logic [CNT_W-1:0]  shadow_fill = '0;
	logic [MODE_W-1:0] shadow_mode = tfifo_pkg::MODE_BLOCK;
	logic [CNT_W-1:0]  shadow_cap  = tfifo_pkg::CAP_RESET;

	fifo_res_t pending_results [$];
	int        bad_results  = 0;
	bit        steady       = 1'b0;
	int        holds_asked  = 0;
	int        holds_done   = 0;

	// capacity as the pointers see it: 0 acts as 1, above 16 acts as 16
	function automatic logic [CNT_W-1:0] live_cap();
		if (shadow_cap == '0)
			return 5'd1;
		if (shadow_cap > 5'd16)
			return 5'd16;
		return shadow_cap;
	endfunction

	function automatic logic [3:0] ring_next(logic [3:0] p);
		logic [CNT_W-1:0] n;
		n = {1'b0, p} + 5'd1;
		return (n >= live_cap()) ? 4'd0 : n[3:0];
	endfunction

	// expected result of one command, advancing the shadow state
	function automatic fifo_res_t next_fifo_result(fifo_cmd_t c);
		fifo_res_t        r;
		logic [CNT_W-1:0] cap;
		bit               store;
		r   = '0;
		cap = live_cap();
		case (c.action) inside
			tfifo_pkg::ACT_PUSH: begin
				store = 1'b1;
				if (shadow_fill >= cap) begin
					if (shadow_mode == tfifo_pkg::MODE_DROP_NEW) begin
						r.status = tfifo_pkg::ST_NEW_DROPPED;
						store    = 1'b0;
					end else if (shadow_mode == tfifo_pkg::MODE_DROP_OLD) begin
						shadow_head = ring_next(shadow_head);
						shadow_fill = shadow_fill - 5'd1;
						r.status    = tfifo_pkg::ST_OLD_DROPPED;
					end else begin
						r.status = tfifo_pkg::ST_FULL_REJECT;
						store    = 1'b0;
					end
				end
				if (store) begin
					shadow_pay[shadow_tail] = c.payload;
					shadow_tag[shadow_tail] = c.tag;
					shadow_tail = ring_next(shadow_tail);
					shadow_fill = shadow_fill + 5'd1;
				end
			end
			tfifo_pkg::ACT_POP, tfifo_pkg::ACT_PEEK: begin
				if (shadow_fill == '0) begin
					r.status = tfifo_pkg::ST_EMPTY;
				end else if (c.action == tfifo_pkg::ACT_POP && c.tag != tfifo_pkg::TAG_ANY &&
						shadow_tag[shadow_head] != c.tag) begin
					r.status = tfifo_pkg::ST_TAG_MISMATCH;
				end else begin
					r.payload = shadow_pay[shadow_head];
					r.tag     = shadow_tag[shadow_head];
					if (c.action == tfifo_pkg::ACT_POP) begin
						shadow_head = ring_next(shadow_head);
						shadow_fill = shadow_fill - 5'd1;
					end
				end
			end
			tfifo_pkg::ACT_CLEAR: begin
				shadow_head = '0;
				shadow_tail = '0;
				shadow_fill = '0;
			end
			default: ;
		endcase
		r.empty = (shadow_fill == '0);
		r.room  = (shadow_fill < cap);
		r.count = shadow_fill;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PAY_W-1:0] random_payload();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// random command; pops often name the tag that is at the head
	function automatic fifo_cmd_t random_cmd(int push_pct);
		fifo_cmd_t c;
		int        r;
		int        t;
		r = $urandom_range(0, 99);
		c.payload = random_payload();
		c.tag     = TAG_W'($urandom_range(0, 6));
		if (r < push_pct) begin
			c.action = tfifo_pkg::ACT_PUSH;
		end else if (r < push_pct + (100 - push_pct) * 6 / 10) begin
			c.action = tfifo_pkg::ACT_POP;
			t = $urandom_range(0, 99);
			if (t < 45)
				c.tag = tfifo_pkg::TAG_ANY;
			else if (t < 75 && shadow_fill != '0)
				c.tag = shadow_tag[shadow_head];
		end else if (r < 97) begin
			c.action = tfifo_pkg::ACT_PEEK;
		end else begin
			c.action = tfifo_pkg::ACT_CLEAR;
		end
		return c;
	endfunction

	function automatic fifo_res_t fifo_res(logic [STATUS_W-1:0] st, logic [TAG_W-1:0] tg,
			logic em, logic rm, logic [CNT_W-1:0] cnt);
		fifo_res_t r;
		r.status  = st;
		r.payload = '0;
		r.tag     = tg;
		r.empty   = em;
		r.room    = rm;
		r.count   = cnt;
		return r;
	endfunction

	function automatic void report_bad(string what, fifo_res_t want, fifo_res_t got);
		bad_results++;
		if (bad_results <= REPORT_LIMIT)
			$display("%0t %s: want st=%0d pay=%h tag=%0d e=%0b r=%0b n=%0d,",
				$realtime, what, want.status, want.payload, want.tag, want.empty,
				want.room, want.count,
				" got st=%0d pay=%h tag=%0d e=%0b r=%0b n=%0d",
				got.status, got.payload, got.tag, got.empty, got.room, got.count);
	endfunction

	// one command transfer; the expectation is queued at the accepting edge
	task automatic send_cmd(input fifo_cmd_t c, input bit fixed, input fifo_res_t fixed_res);
		int        gap;
		fifo_res_t r;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= c.action;
		cmd_ch.type_tag   <= c.tag;
		cmd_ch.payload_in <= c.payload;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		r = next_fifo_result(c);
		pending_results.push_back(fixed ? fixed_res : r);
	endtask

	// register write; valid is left high for the caller to lower
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == tfifo_pkg::REG_FULL_MODE)
			shadow_mode = val[MODE_W-1:0];
		else
			shadow_cap = val;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// command side
	initial begin
		opening_row_t opening_rows [$];
		phase_t       plan [PHASES];
		fifo_cmd_t    c;
		logic [PAY_W-1:0] p;

		cmd_ch.valid      = 1'b0;
		cmd_ch.action     = tfifo_pkg::ACT_PUSH;
		cmd_ch.type_tag   = tfifo_pkg::TAG_ANY;
		cmd_ch.payload_in = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = tfifo_pkg::REG_FULL_MODE;
		cfg_ch.data       = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue after reset
		opening_rows.push_back('{'{tfifo_pkg::ACT_POP, tfifo_pkg::TAG_ANY, 64'd0}, 1'b1,
			fifo_res(tfifo_pkg::ST_EMPTY, tfifo_pkg::TAG_ANY, 1'b1, 1'b1, 5'd0)});
		opening_rows.push_back('{'{tfifo_pkg::ACT_PEEK, tfifo_pkg::TAG_ANY, 64'd0}, 1'b1,
			fifo_res(tfifo_pkg::ST_EMPTY, tfifo_pkg::TAG_ANY, 1'b1, 1'b1, 5'd0)});
		// fill every slot, so no slot is ever read unwritten later on
		for (int k = 0; k < 16; k++) begin
			case (k)
				0:       p = '0;
				1:       p = '1;
				2:       p = {16{4'h5}};
				3:       p = {16{4'hA}};
				4:       p = {1'b1, 63'd0};
				default: p = {8{8'(k * 37 + 11)}};
			endcase
			opening_rows.push_back('{'{tfifo_pkg::ACT_PUSH, TAG_W'((k + 1) % 7), p},
				1'b0, '0});
		end
		// full under block policy
		opening_rows.push_back('{'{tfifo_pkg::ACT_PUSH, 3'd6, '1}, 1'b1,
			fifo_res(tfifo_pkg::ST_FULL_REJECT, tfifo_pkg::TAG_ANY, 1'b0, 1'b0, 5'd16)});
		opening_rows.push_back('{'{tfifo_pkg::ACT_PEEK, 3'd5, 64'd0}, 1'b0, '0});
		// head holds tag 1, so a pop for tag 2 is refused
		opening_rows.push_back('{'{tfifo_pkg::ACT_POP, 3'd2, 64'd0}, 1'b1,
			fifo_res(tfifo_pkg::ST_TAG_MISMATCH, tfifo_pkg::TAG_ANY, 1'b0, 1'b0, 5'd16)});
		opening_rows.push_back('{'{tfifo_pkg::ACT_POP, 3'd1, 64'd0}, 1'b0, '0});
		opening_rows.push_back('{'{tfifo_pkg::ACT_POP, tfifo_pkg::TAG_ANY, 64'd0}, 1'b0, '0});
		opening_rows.push_back('{'{tfifo_pkg::ACT_CLEAR, 3'd3, '1}, 1'b1,
			fifo_res(tfifo_pkg::ST_OK, tfifo_pkg::TAG_ANY, 1'b1, 1'b1, 5'd0)});

		foreach (opening_rows[i])
			send_cmd(opening_rows[i].cmd, opening_rows[i].fixed, opening_rows[i].res);

		// settings per phase, the capacity extremes among them
		plan[0] = '{tfifo_pkg::MODE_DROP_NEW, 5'd4,  60, 1'b0, 1'b0};
		plan[1] = '{tfifo_pkg::MODE_DROP_OLD, 5'd1,  60, 1'b0, 1'b0};
		plan[2] = '{MODE_RESERVED,            5'd0,  55, 1'b0, 1'b0};
		plan[3] = '{tfifo_pkg::MODE_DROP_OLD, 5'd31, 65, 1'b1, 1'b1};
		plan[4] = '{tfifo_pkg::MODE_BLOCK,    5'd16, 50, 1'b0, 1'b0};
		plan[5] = '{tfifo_pkg::MODE_DROP_OLD, CNT_W'($urandom_range(2, 15)), 55, 1'b0, 1'b0};
		plan[6] = '{tfifo_pkg::MODE_DROP_NEW, 5'd17, 70, 1'b1, 1'b0};
		plan[7] = '{tfifo_pkg::MODE_DROP_OLD, 5'd3,  50, 1'b0, 1'b0};

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			// queue may still hold entries across a capacity change
			write_reg(tfifo_pkg::REG_FULL_MODE, CFG_DATA_W'(plan[ph].mode));
			write_reg(tfifo_pkg::REG_CAPACITY, plan[ph].cap);
			cfg_ch.valid <= 1'b0;
			steady = plan[ph].calm;
			if (plan[ph].hold)
				holds_asked++;
			repeat (ITEMS_PER_PHASE) begin
				c = random_cmd(plan[ph].push_pct);
				send_cmd(c, 1'b0, '0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (bad_results == 0)
			$display("[typed_fifo_with_overflow_modes] OK");
		else
			$display("[typed_fifo_with_overflow_modes] ERROR");
		$finish;
	end

	// result side: random back-pressure and checking
	initial begin
		fifo_res_t got;
		fifo_res_t want;
		int        gap;

		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done < holds_asked) begin
				holds_done++;
				gap = LONG_HOLD;
			end else begin
				gap = steady ? 0 : pick_gap();
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			got.status  = rsp_ch.status;
			got.payload = rsp_ch.payload_out;
			got.tag     = rsp_ch.type_out;
			got.empty   = rsp_ch.is_empty;
			got.room    = rsp_ch.has_room;
			got.count   = rsp_ch.entry_count;
			if (pending_results.size() == 0) begin
				report_bad("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.payload !== want.payload ||
						got.tag !== want.tag || got.empty !== want.empty ||
						got.room !== want.room || got.count !== want.count)
					report_bad("result mismatch", want, got);
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("[typed_fifo_with_overflow_modes] ERROR");
		$finish;
	end

endmodule
